// ----- sv/bved_pkg.sv -----
// Shared types, constants and register codes for the 6-neighbour volume erode/dilate block.
`timescale 1ns / 1ps

package bved_pkg;

   // Volume limits
   localparam int MAX_X = 256;
   localparam int MAX_Y = 256;
   localparam int MAX_Z = 4096;

   localparam int XW = $clog2(MAX_X);
   localparam int YW = $clog2(MAX_Y);
   localparam int ZW = $clog2(MAX_Z);

   // Plane store: one word per (y,x), one bit per plane parity
   localparam int DEPTH  = MAX_X * MAX_Y;
   localparam int AW     = $clog2(DEPTH);
   localparam int WORD_W = 2;

   // Read ports of the store, two on each copy
   localparam int RD_PORTS = 4;
   localparam int RD_CTR   = 0;
   localparam int RD_RGT   = 1;
   localparam int RD_DN    = 2;
   localparam int RD_UP    = 3;

   // Configuration port
   localparam int SIZE_XY_W  = 9;
   localparam int SIZE_Z_W   = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_ADDR_W-1:0] REG_DILATE_MODE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_X      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_Y      = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SIZE_Z      = 2'd3;

   localparam logic [SIZE_XY_W-1:0] RESET_SIZE_X = 9'd256;
   localparam logic [SIZE_XY_W-1:0] RESET_SIZE_Y = 9'd256;
   localparam logic [SIZE_Z_W-1:0]  RESET_SIZE_Z = 13'd256;

   // Channel beats
   typedef struct packed {
      logic mask_bit;
      logic drain;
   } req_beat_type;

   typedef struct packed {
      logic result_bit;
      logic last_voxel;
   } rsp_beat_type;

   // Effective configuration (sizes as last positions)
   typedef struct packed {
      logic          dilate;
      logic [XW-1:0] x_last;
      logic [YW-1:0] y_last;
      logic [ZW-1:0] z_last;
   } cfg_type;

   // One accepted beat handed from the sequencer to the evaluation stage
   typedef struct packed {
      logic                         valid;
      logic                         emit;
      logic                         write;
      logic                         voxel;
      logic [XW-1:0]                x;
      logic [YW-1:0]                y;
      logic [ZW-1:0]                z;
      logic [AW-1:0]                wr_addr;
      logic                         wr_slot;
      logic [RD_PORTS-1:0][AW-1:0]  rd_addr;
   } issue_type;

   // Store write, common to both copies
   typedef struct packed {
      logic              en;
      logic [AW-1:0]     addr;
      logic [WORD_W-1:0] data;
   } wr_type;

endpackage

// ----- sv/bved_ram.sv -----
// Generic synchronous RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module bved_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ----- sv/bved_seq.sv -----
// Sequencer: configuration registers, input/output position counters and store read issue.
`timescale 1ns / 1ps

module bved_seq
   import bved_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  req_beat_type          req_data,
   input  logic                  slot_free,
   output issue_type             issue,
   output cfg_type               cfg
);

   function automatic logic [XW-1:0] last_x(input logic [SIZE_XY_W-1:0] s);
      logic [XW-1:0] r;
      if (s == '0) r = '0;
      else if (32'(s) > MAX_X) r = XW'(MAX_X - 1);
      else r = XW'(s - 1'b1);
      return r;
   endfunction

   function automatic logic [YW-1:0] last_y(input logic [SIZE_XY_W-1:0] s);
      logic [YW-1:0] r;
      if (s == '0) r = '0;
      else if (32'(s) > MAX_Y) r = YW'(MAX_Y - 1);
      else r = YW'(s - 1'b1);
      return r;
   endfunction

   function automatic logic [ZW-1:0] last_z(input logic [SIZE_Z_W-1:0] s);
      logic [ZW-1:0] r;
      if (s == '0) r = '0;
      else if (32'(s) > MAX_Z) r = ZW'(MAX_Z - 1);
      else r = ZW'(s - 1'b1);
      return r;
   endfunction

   function automatic logic [AW-1:0] pos_addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
      return AW'(y) * AW'(MAX_X) + AW'(x);
   endfunction

   logic                 dilate_ff, dilate_in;
   logic [SIZE_XY_W-1:0] size_x_ff, size_x_in;
   logic [SIZE_XY_W-1:0] size_y_ff, size_y_in;
   logic [SIZE_Z_W-1:0]  size_z_ff, size_z_in;
   logic [XW-1:0]        in_x_ff, in_x_in, out_x_ff, out_x_in;
   logic [YW-1:0]        in_y_ff, in_y_in, out_y_ff, out_y_in;
   logic [ZW-1:0]        in_z_ff, in_z_in, out_z_ff, out_z_in;
   logic                 in_done_ff, in_done_in;

   logic          fire, voxel_go, emit_go, out_last, restart;
   logic [AW-1:0] in_addr;

   // Effective sizes
   always_comb begin
      cfg.dilate = dilate_ff;
      cfg.x_last = last_x(size_x_ff);
      cfg.y_last = last_y(size_y_ff);
      cfg.z_last = last_z(size_z_ff);
   end

   // Beat classification
   assign fire     = req_valid & slot_free;
   assign voxel_go = fire & ~req_data.drain & ~in_done_ff;
   assign emit_go  = fire & (req_data.drain ? in_done_ff : (~in_done_ff & (in_z_ff != '0)));
   assign out_last = (out_x_ff == cfg.x_last) && (out_y_ff == cfg.y_last) &&
                     (out_z_ff == cfg.z_last);
   assign in_addr  = pos_addr(in_y_ff, in_x_ff);

   // Store reads for this beat: centre word (also the write target), right, down, up
   always_comb begin
      issue.valid   = voxel_go | emit_go;
      issue.emit    = emit_go;
      issue.write   = voxel_go;
      issue.voxel   = req_data.mask_bit & ~req_data.drain;
      issue.x       = out_x_ff;
      issue.y       = out_y_ff;
      issue.z       = out_z_ff;
      issue.wr_addr = in_addr;
      issue.wr_slot = in_z_ff[0];
      issue.rd_addr[RD_CTR] = in_done_ff ? pos_addr(out_y_ff, out_x_ff) : in_addr;
      issue.rd_addr[RD_RGT] = pos_addr(out_y_ff, out_x_ff + 1'b1);
      issue.rd_addr[RD_DN]  = pos_addr(out_y_ff + 1'b1, out_x_ff);
      issue.rd_addr[RD_UP]  = pos_addr(out_y_ff - 1'b1, out_x_ff);
   end

   // Register writes and position counters
   always_comb begin
      dilate_in  = dilate_ff;
      size_x_in  = size_x_ff;
      size_y_in  = size_y_ff;
      size_z_in  = size_z_ff;
      in_x_in    = in_x_ff;
      in_y_in    = in_y_ff;
      in_z_in    = in_z_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_z_in   = out_z_ff;
      in_done_in = in_done_ff;
      restart    = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            REG_DILATE_MODE: begin
               dilate_in = csr_wdata[0];
            end
            REG_SIZE_X: begin
               size_x_in = csr_wdata[SIZE_XY_W-1:0];
               restart   = 1'b1;
            end
            REG_SIZE_Y: begin
               size_y_in = csr_wdata[SIZE_XY_W-1:0];
               restart   = 1'b1;
            end
            REG_SIZE_Z: begin
               size_z_in = csr_wdata[SIZE_Z_W-1:0];
               restart   = 1'b1;
            end
            default: begin
            end
         endcase
      end else begin
         // input raster position
         if (voxel_go) begin
            if (in_x_ff == cfg.x_last) begin
               in_x_in = '0;
               if (in_y_ff == cfg.y_last) begin
                  in_y_in = '0;
                  if (in_z_ff == cfg.z_last) begin
                     in_z_in    = '0;
                     in_done_in = 1'b1;
                  end else begin
                     in_z_in = in_z_ff + 1'b1;
                  end
               end else begin
                  in_y_in = in_y_ff + 1'b1;
               end
            end else begin
               in_x_in = in_x_ff + 1'b1;
            end
         end
         // output raster position; the final voxel starts a new volume
         if (emit_go) begin
            if (out_last) begin
               restart = 1'b1;
            end else if (out_x_ff == cfg.x_last) begin
               out_x_in = '0;
               if (out_y_ff == cfg.y_last) begin
                  out_y_in = '0;
                  out_z_in = out_z_ff + 1'b1;
               end else begin
                  out_y_in = out_y_ff + 1'b1;
               end
            end else begin
               out_x_in = out_x_ff + 1'b1;
            end
         end
      end

      if (restart) begin
         in_x_in    = '0;
         in_y_in    = '0;
         in_z_in    = '0;
         out_x_in   = '0;
         out_y_in   = '0;
         out_z_in   = '0;
         in_done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dilate_ff  <= 1'b0;
         size_x_ff  <= RESET_SIZE_X;
         size_y_ff  <= RESET_SIZE_Y;
         size_z_ff  <= RESET_SIZE_Z;
         in_x_ff    <= '0;
         in_y_ff    <= '0;
         in_z_ff    <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         out_z_ff   <= '0;
         in_done_ff <= 1'b0;
      end else begin
         dilate_ff  <= dilate_in;
         size_x_ff  <= size_x_in;
         size_y_ff  <= size_y_in;
         size_z_ff  <= size_z_in;
         in_x_ff    <= in_x_in;
         in_y_ff    <= in_y_in;
         in_z_ff    <= in_z_in;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_z_ff   <= out_z_in;
         in_done_ff <= in_done_in;
      end
   end

endmodule

// ----- sv/bved_eval.sv -----
// Evaluation stage: read forwarding, store write-back, neighbourhood test and output register.
`timescale 1ns / 1ps

module bved_eval
   import bved_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  issue_type                         issue,
   input  cfg_type                           cfg,
   input  logic [RD_PORTS-1:0][WORD_W-1:0]   rd_data,
   output wr_type                            wr,
   output logic                              slot_free,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rsp_beat_type                      rsp_data
);

   // Stage registers
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_emit_ff;
   logic                  wpend_ff, wpend_in;
   logic                  s1_voxel_ff;
   logic [XW-1:0]         s1_x_ff;
   logic [YW-1:0]         s1_y_ff;
   logic [ZW-1:0]         s1_z_ff;
   logic [AW-1:0]         s1_waddr_ff;
   logic                  s1_wslot_ff;
   logic [RD_PORTS-1:0]   fwd_hit_ff, fwd_hit_in;
   logic [WORD_W-1:0]     fwd_word_ff;
   logic                  left_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          rsp_data_ff;

   logic [RD_PORTS-1:0][WORD_W-1:0] eff;
   logic [WORD_W-1:0]               merged;
   logic                            s1_go;
   logic                            p, c, below, right, down, up;
   logic                            has_l, has_r, has_u, has_d, has_b, has_a;
   logic                            all_set, any_set, face;
   rsp_beat_type                    result;

   // Read data with the write committed on the issuing edge forwarded in
   always_comb begin
      for (int i = 0; i < RD_PORTS; i++) begin
         eff[i] = fwd_hit_ff[i] ? fwd_word_ff : rd_data[i];
      end
   end

   // Write-back: replace this beat's plane bit, keep the other plane
   always_comb begin
      merged              = eff[RD_CTR];
      merged[s1_wslot_ff] = s1_voxel_ff;
      wr.en   = wpend_ff;
      wr.addr = s1_waddr_ff;
      wr.data = merged;
   end

   always_comb begin
      for (int i = 0; i < RD_PORTS; i++) begin
         fwd_hit_in[i] = wr.en && (s1_waddr_ff == issue.rd_addr[i]);
      end
   end

   // Six-neighbour test
   always_comb begin
      p     = s1_z_ff[0];
      c     = eff[RD_CTR][p];
      below = eff[RD_CTR][~p];
      right = eff[RD_RGT][p];
      down  = eff[RD_DN][p];
      up    = eff[RD_UP][p];
      has_l = (s1_x_ff != '0);
      has_r = (s1_x_ff != cfg.x_last);
      has_u = (s1_y_ff != '0);
      has_d = (s1_y_ff != cfg.y_last);
      has_b = (s1_z_ff != '0);
      has_a = (s1_z_ff != cfg.z_last);
      all_set = c & (~has_l | left_ff) & (~has_r | right) & (~has_u | up) &
                (~has_d | down) & (~has_b | below) & (~has_a | s1_voxel_ff);
      any_set = c | (has_l & left_ff) | (has_r & right) | (has_u & up) |
                (has_d & down) | (has_b & below) | (has_a & s1_voxel_ff);
      face = ~(has_l & has_r & has_u & has_d & has_b & has_a);
      result.result_bit = cfg.dilate ? any_set : (~face & all_set);
      result.last_voxel = ~has_r & ~has_d & ~has_a;
   end

   // Flow: the stage empties unless its result finds the output register blocked
   assign s1_go     = s1_valid_ff & (~s1_emit_ff | ~rsp_valid_ff | rsp_ready);
   assign slot_free = ~s1_valid_ff | s1_go;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue.valid) s1_valid_in = 1'b1;
      else if (s1_go) s1_valid_in = 1'b0;
      wpend_in = issue.valid & issue.write;
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_emit_ff) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         wpend_ff     <= 1'b0;
         fwd_hit_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         wpend_ff     <= wpend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (issue.valid) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (issue.valid) begin
         s1_emit_ff  <= issue.emit;
         s1_voxel_ff <= issue.voxel;
         s1_x_ff     <= issue.x;
         s1_y_ff     <= issue.y;
         s1_z_ff     <= issue.z;
         s1_waddr_ff <= issue.wr_addr;
         s1_wslot_ff <= issue.wr_slot;
         fwd_word_ff <= merged;
      end
      if (s1_go && s1_emit_ff) begin
         left_ff     <= c;
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/binary_volume_erode_dilate_6n_core.sv -----
// Top level of the streaming 6-neighbour binary volume erode/dilate block.
// Path: the beat that causes a result is registered in the evaluation stage, then the result
// in the output register. Throughput: one beat per cycle unless the output stalls; each voxel
// beat does a read-modify-write (centre word) and three neighbour reads over two 2-port copies.
// Reset: synchronous; clears positions, pipeline valids and registers to their defaults.
// The plane store is not cleared: every entry that the test uses is written before it is read.
`timescale 1ns / 1ps

module binary_volume_erode_dilate_6n_core
   import bved_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_beat_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_beat_type          rsp_data
);

   issue_type                        issue;
   cfg_type                          cfg;
   wr_type                           wr;
   logic [RD_PORTS-1:0][WORD_W-1:0]  rd_data;
   logic                             slot_free;

   assign req_ready = slot_free;

   bved_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_data  (req_data),
      .slot_free (slot_free),
      .issue     (issue),
      .cfg       (cfg)
   );

   // Two identical copies of the plane store for four reads per cycle
   bved_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_a (
      .clock   (clock),
      .we      (wr.en),
      .waddr   (wr.addr),
      .wdata   (wr.data),
      .re      (issue.valid),
      .raddr_a (issue.rd_addr[RD_CTR]),
      .raddr_b (issue.rd_addr[RD_RGT]),
      .rdata_a (rd_data[RD_CTR]),
      .rdata_b (rd_data[RD_RGT])
   );

   bved_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store_b (
      .clock   (clock),
      .we      (wr.en),
      .waddr   (wr.addr),
      .wdata   (wr.data),
      .re      (issue.valid),
      .raddr_a (issue.rd_addr[RD_DN]),
      .raddr_b (issue.rd_addr[RD_UP]),
      .rdata_a (rd_data[RD_DN]),
      .rdata_b (rd_data[RD_UP])
   );

   bved_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .cfg       (cfg),
      .rd_data   (rd_data),
      .wr        (wr),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A store write is only ever the write-back of the beat issued in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      wr.en |-> $past(issue.valid && issue.write))
      else $error("store write without an issued voxel beat");

   // Nothing is issued unless a beat is taken on the input
   assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> (req_valid && req_ready))
      else $error("store access issued without an accepted beat");

   // The input only stalls behind a blocked output register
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the output side is free");

endmodule

// ----- tb/sv/tb_binary_volume_erode_dilate_6n_core.sv -----
// Self-checking bench for the 6-neighbour volume erode/dilate core: directed and random volumes.
`timescale 1ns / 1ps

module tb_binary_volume_erode_dilate_6n_core;
   import bved_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned RANDOM_ITEMS = 400;
   localparam int unsigned IDLE_PCT     = 27;
   localparam int unsigned FLUSH_CYCLES = 8;

   // Tracks the volume stream, predicts each output voxel and checks result beats
   class voxel_scoreboard;
      bit                    dilate;
      bit [SIZE_XY_W-1:0]    size_x_reg;
      bit [SIZE_XY_W-1:0]    size_y_reg;
      bit [SIZE_Z_W-1:0]     size_z_reg;
      bit                    plane_store [2*MAX_X*MAX_Y];
      int unsigned           in_x, in_y, in_z;
      int unsigned           out_x, out_y, out_z;
      bit                    vol_in;
      rsp_beat_type          due_results [$];
      int unsigned           results_seen;
      int unsigned           mismatches;

      function new();
         dilate       = 1'b0;
         size_x_reg   = RESET_SIZE_X;
         size_y_reg   = RESET_SIZE_Y;
         size_z_reg   = RESET_SIZE_Z;
         results_seen = 0;
         mismatches   = 0;
         restart_stream();
      endfunction

      function int unsigned clamp_size(int unsigned v, int unsigned hi);
         if (v < 1) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function int unsigned slot(int unsigned p, int unsigned y, int unsigned x);
         return ((p & 1) * MAX_Y + y) * MAX_X + x;
      endfunction

      function void restart_stream();
         in_x   = 0;
         in_y   = 0;
         in_z   = 0;
         out_x  = 0;
         out_y  = 0;
         out_z  = 0;
         vol_in = 1'b0;
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction

      function void write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
         case (addr)
            REG_DILATE_MODE: dilate = data[0];
            REG_SIZE_X: begin
               size_x_reg = data[SIZE_XY_W-1:0];
               restart_stream();
            end
            REG_SIZE_Y: begin
               size_y_reg = data[SIZE_XY_W-1:0];
               restart_stream();
            end
            REG_SIZE_Z: begin
               size_z_reg = data[SIZE_Z_W-1:0];
               restart_stream();
            end
            default: ;
         endcase
      endfunction

      // Window evaluation of the next output voxel; above is the voxel one plane up
      function void eval_voxel(bit above);
         int unsigned  nx, ny, nz, p, q;
         bit           centre, all_set, any_set, on_face, v;
         rsp_beat_type beat;
         nx      = clamp_size(size_x_reg, MAX_X);
         ny      = clamp_size(size_y_reg, MAX_Y);
         nz      = clamp_size(size_z_reg, MAX_Z);
         p       = out_z & 1;
         q       = (out_z + 1) & 1;
         centre  = plane_store[slot(p, out_y, out_x)];
         all_set = centre;
         any_set = centre;
         if (out_x > 0) begin
            v = plane_store[slot(p, out_y, out_x - 1)];
            all_set &= v;
            any_set |= v;
         end
         if (out_y > 0) begin
            v = plane_store[slot(p, out_y - 1, out_x)];
            all_set &= v;
            any_set |= v;
         end
         if (out_z > 0) begin
            v = plane_store[slot(q, out_y, out_x)];
            all_set &= v;
            any_set |= v;
         end
         if (out_x < nx - 1) begin
            v = plane_store[slot(p, out_y, out_x + 1)];
            all_set &= v;
            any_set |= v;
         end
         if (out_y < ny - 1) begin
            v = plane_store[slot(p, out_y + 1, out_x)];
            all_set &= v;
            any_set |= v;
         end
         if (out_z < nz - 1) begin
            all_set &= above;
            any_set |= above;
         end
         on_face = (out_x == 0) || (out_y == 0) || (out_z == 0) ||
                   (out_x == nx - 1) || (out_y == ny - 1) || (out_z == nz - 1);
         beat.result_bit = dilate ? any_set : (!on_face && all_set);
         beat.last_voxel = (out_x == nx - 1) && (out_y == ny - 1) && (out_z == nz - 1);
         due_results.push_back(beat);

         // step the output position; the final voxel ends the volume
         if (beat.last_voxel) begin
            restart_stream();
         end else begin
            out_x++;
            if (out_x >= nx) begin
               out_x = 0;
               out_y++;
               if (out_y >= ny) begin
                  out_y = 0;
                  out_z++;
               end
            end
         end
      endfunction

      // Accepted request beat
      function void note_beat(req_beat_type beat);
         int unsigned nx, ny, nz;
         nx = clamp_size(size_x_reg, MAX_X);
         ny = clamp_size(size_y_reg, MAX_Y);
         nz = clamp_size(size_z_reg, MAX_Z);
         // flush beats only count once the whole volume is in
         if (beat.drain) begin
            if (vol_in) eval_voxel(1'b0);
            return;
         end
         if (vol_in) return;
         // plane z-2 is read before the new voxel overwrites it
         if (in_z >= 1) eval_voxel(beat.mask_bit);
         plane_store[slot(in_z, in_y, in_x)] = beat.mask_bit;
         in_x++;
         if (in_x >= nx) begin
            in_x = 0;
            in_y++;
            if (in_y >= ny) begin
               in_y = 0;
               in_z++;
               if (in_z >= nz) begin
                  in_z   = 0;
                  vol_in = 1'b1;
               end
            end
         end
      endfunction

      task report_mismatch(input string what);
         if (mismatches < 100) $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Accepted result beat against the oldest due result
      task check_beat(input rsp_beat_type got);
         rsp_beat_type want;
         results_seen++;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("result %0d with none due (bit %b last %b)",
                                      results_seen, got.result_bit, got.last_voxel));
            return;
         end
         want = due_results.pop_front();
         if (got.result_bit !== want.result_bit)
            report_mismatch($sformatf("result %0d result_bit %b, want %b",
                                      results_seen, got.result_bit, want.result_bit));
         if (got.last_voxel !== want.last_voxel)
            report_mismatch($sformatf("result %0d last_voxel %b, want %b",
                                      results_seen, got.last_voxel, want.last_voxel));
      endtask
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_beat_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_beat_type          rsp_data;

   voxel_scoreboard sb;
   bit              calm         = 1'b0;
   int unsigned     cycles       = 0;
   int unsigned     random_items = 0;

   always #2 clock = ~clock;

   binary_volume_erode_dilate_6n_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_beat(rsp_data);
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("binary_volume_erode_dilate_6n_core verification failed");
         $finish;
      end
   end

   // One request beat; valid stays up across back-to-back beats
   task automatic send_beat(input bit mask, input bit flush);
      req_beat_type beat;
      beat.mask_bit = mask;
      beat.drain    = flush;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_beat(beat);
   endtask

   // Wait for every due result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (FLUSH_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input int unsigned value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      sb.write_register(addr, value[CSR_DATA_W-1:0]);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input bit mode, input int unsigned sx, sy, sz);
      write_csr(REG_DILATE_MODE, mode);
      write_csr(REG_SIZE_X, sx);
      write_csr(REG_SIZE_Y, sy);
      write_csr(REG_SIZE_Z, sz);
   endtask

   // Whole volume plus its flush beats; noise adds beats the core must ignore
   task automatic send_volume(input int unsigned nx, ny, nz, density, input bit noise);
      int unsigned i;
      for (i = 0; i < nx * ny * nz; i++) begin
         if (noise && $urandom_range(99) < 5) send_beat(1'($urandom_range(1)), 1'b1);
         send_beat($urandom_range(99) < density, 1'b0);
      end
      if (noise) repeat ($urandom_range(3, 1)) send_beat(1'($urandom_range(1)), 1'b0);
      for (i = 0; i < nx * ny; i++) send_beat(1'($urandom_range(1)), 1'b1);
      if (noise) repeat ($urandom_range(2, 1)) send_beat(1'($urandom_range(1)), 1'b1);
   endtask

   initial begin
      int unsigned i, v, vols, sx, sy, sz, nx, ny, nz, cut, density;
      bit          dropped;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // erosion left at its reset mode; flush with nothing pending goes first
      write_csr(REG_SIZE_X, 3);
      write_csr(REG_SIZE_Y, 3);
      write_csr(REG_SIZE_Z, 3);
      send_beat(1'b1, 1'b1);
      // solid cube: only the centre survives; early flush and late voxel are ignored
      for (i = 0; i < 27; i++) begin
         if (i == 5) send_beat(1'b0, 1'b1);
         send_beat(1'b1, 1'b0);
      end
      send_beat(1'b0, 1'b0);
      for (i = 0; i < 9; i++) send_beat(1'b0, 1'b1);

      // dilation of a lone centre voxel, mode switched back part way through
      settle();
      write_csr(REG_DILATE_MODE, 1);
      for (i = 0; i < 22; i++) send_beat(i == 13, 1'b0);
      settle();
      write_csr(REG_DILATE_MODE, 0);
      for (i = 22; i < 27; i++) send_beat(1'b0, 1'b0);
      for (i = 0; i < 9; i++) send_beat(1'b0, 1'b1);

      // size write part way through a volume restarts the stream
      settle();
      configure(1'b1, 2, 2, 2);
      for (i = 0; i < 6; i++) send_beat(1'b1, 1'b0);
      settle();
      write_csr(REG_SIZE_Y, 2);
      send_volume(2, 2, 2, 50, 1'b0);

      // zero sizes act as one; single planes leave only on flush
      settle();
      configure(1'b1, 0, 0, 0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b1);
      settle();
      configure(1'b0, 5, 3, 1);
      send_volume(5, 3, 1, 100, 1'b0);

      // largest row and column, the row size above its limit
      settle();
      configure(1'b1, 9'h1FF, 1, 1);
      send_volume(256, 1, 1, 15, 1'b0);
      settle();
      configure(1'b1, 1, 256, 1);
      send_volume(1, 256, 1, 15, 1'b0);
      // plane count above the limit; the stream is left part way for the next size writes
      settle();
      configure(1'b1, 1, 1, 13'h1FFF);
      for (i = 0; i < 20; i++) send_beat(1'($urandom_range(1)), 1'b0);

      // random settings of mostly small volumes; some abandoned part way
      while (random_items < RANDOM_ITEMS) begin
         settle();
         calm = (random_items >= 120) && (random_items < 280);
         sx   = $urandom_range(8);
         sy   = $urandom_range(6);
         sz   = $urandom_range(4);
         if ($urandom_range(99) < 5) begin
            sx = $urandom_range(40, 16);
            sy = $urandom_range(2);
            sz = $urandom_range(2);
         end
         configure(1'($urandom_range(1)), sx, sy, sz);
         nx      = sb.clamp_size(sx, MAX_X);
         ny      = sb.clamp_size(sy, MAX_Y);
         nz      = sb.clamp_size(sz, MAX_Z);
         vols    = $urandom_range(3, 1);
         dropped = 1'b0;
         for (v = 0; v < vols && !dropped && random_items < RANDOM_ITEMS; v++) begin
            if ($urandom_range(99) < 10) begin
               // the size writes of the next setting restart the stream
               cut = $urandom_range(nx * ny * nz, 1);
               for (i = 0; i < cut; i++) send_beat(1'($urandom_range(1)), 1'b0);
               random_items += cut;
               dropped = 1'b1;
            end else begin
               case ($urandom_range(3))
                  0:       density = 15;
                  1:       density = 50;
                  2:       density = 85;
                  default: density = 100;
               endcase
               send_volume(nx, ny, nz, density, $urandom_range(99) < 30);
               random_items += nx * ny * nz + nx * ny;
            end
         end
      end
      calm = 1'b0;

      settle();
      if (sb.mismatches == 0) begin
         $display("binary_volume_erode_dilate_6n_core verification clean");
      end else begin
         $display("binary_volume_erode_dilate_6n_core verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/bved_pkg.sv
sv/bved_ram.sv
sv/bved_seq.sv
sv/bved_eval.sv
sv/binary_volume_erode_dilate_6n_core.sv
tb/sv/tb_binary_volume_erode_dilate_6n_core.sv
